// File: src/bpc_pkg.sv
`timescale 1ns / 1ps
package bpc_pkg;
   localparam int MAX_PATTERNS    = 6;
   localparam int MAX_PATTERN_LEN = 8;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int FILL_W          = $clog2(MAX_PATTERN_LEN + 1);
   localparam int CNT_W           = $clog2(MAX_PATTERN_LEN + 1);
   localparam int COUNT_W         = 3;
   localparam logic [7:0] SYM_SPACE   = 8'h20;
   localparam logic [7:0] SYM_NEWLINE = 8'h0A;
   localparam logic [15:0] WORD_MAX   = 16'hFFFF;
   localparam logic [31:0] GRAND_MAX  = 32'hFFFFFFFF;
   localparam logic [CSR_INDEX_W-1:0] REG_CHARS_A = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTHS = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT   = 3'd7;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [15:0] word_covered;
      logic [31:0] total_covered;
      logic        last;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic             close;     // word ends here
      logic             eot;
      logic             retire;    // oldest mark leaves window covered
      logic [CNT_W-1:0] flush_cnt; // final marks counted at close
   } evt_type;
endpackage

// File: src/bpc_front.sv
`timescale 1ns / 1ps
module bpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                 take,
   input  bpc_pkg::req_type     req,
   output bpc_pkg::evt_type     evt
);
   localparam int L = bpc_pkg::MAX_PATTERN_LEN;
   localparam int P = bpc_pkg::MAX_PATTERNS;

   logic [63:0] chars_ff [P];
   logic [23:0] lengths_ff;
   logic [bpc_pkg::COUNT_W-1:0] count_ff;
   logic [7:0] win_ff [L];
   logic [7:0] win_in [L];
   logic [L-1:0] marks_ff, marks_in;
   logic [bpc_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic is_sym;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < P; p++) chars_ff[p] <= '0;
         lengths_ff <= '0;
         count_ff   <= '0;
      end else if (csr_write) begin
         if (csr_index == bpc_pkg::REG_LENGTHS) lengths_ff <= csr_data[23:0];
         else if (csr_index == bpc_pkg::REG_COUNT)
            count_ff <= csr_data[bpc_pkg::COUNT_W-1:0];
         else
            for (int p = 0; p < P; p++)
               if (csr_index == bpc_pkg::REG_CHARS_A + bpc_pkg::CSR_INDEX_W'(p))
                  chars_ff[p] <= csr_data;
      end
   end

   assign is_sym = !req.end_of_text && req.symbol != bpc_pkg::SYM_SPACE
                   && req.symbol != bpc_pkg::SYM_NEWLINE;

   always_comb begin
      logic [3:0] len;
      logic fwd, rev;
      logic [bpc_pkg::CNT_W-1:0] cnt;
      len = '0;
      fwd = 1'b0;
      rev = 1'b0;
      for (int i = 0; i < L; i++) win_in[i] = win_ff[i];
      marks_in = marks_ff;
      fill_in  = fill_ff;
      cnt = '0;
      evt = '0;
      evt.close = !is_sym;
      evt.eot   = req.end_of_text;
      if (is_sym) begin
         evt.retire = (fill_ff >= bpc_pkg::FILL_W'(L)) && marks_ff[L-1];
         win_in[0] = req.symbol;
         for (int i = 1; i < L; i++) win_in[i] = win_ff[i-1];
         marks_in = {marks_ff[L-2:0], 1'b0};
         if (fill_ff < bpc_pkg::FILL_W'(L)) fill_in = fill_ff + 1'b1;
         for (int p = 0; p < P; p++) begin
            len = lengths_ff[4*p +: 4];
            if (len > 4'(L)) len = 4'(L);
            fwd = 1'b1;
            rev = 1'b1;
            for (int k = 0; k < L; k++)
               if (k < int'(len)) begin
                  if (chars_ff[p][8*k +: 8] != win_in[int'(len)-1-k]) fwd = 1'b0;
                  if (chars_ff[p][8*k +: 8] != win_in[k]) rev = 1'b0;
               end
            if (p < int'(count_ff) && len != 0 && bpc_pkg::FILL_W'(len) <= fill_in
                && (fwd || rev))
               for (int i = 0; i < L; i++)
                  if (i < int'(len)) marks_in[i] = 1'b1;
         end
      end else begin
         for (int i = 0; i < L; i++)
            if (bpc_pkg::FILL_W'(i) < fill_ff && marks_ff[i]) cnt = cnt + 1'b1;
         evt.flush_cnt = cnt;
         for (int i = 0; i < L; i++) win_in[i] = '0;
         marks_in = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) win_ff[i] <= '0;
         marks_ff <= '0;
         fill_ff  <= '0;
      end else if (take) begin
         for (int i = 0; i < L; i++) win_ff[i] <= win_in[i];
         marks_ff <= marks_in;
         fill_ff  <= fill_in;
      end
   end
endmodule

// File: src/bpc_queue.sv
`timescale 1ns / 1ps
module bpc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bpc_pkg::evt_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output bpc_pkg::evt_type pop_data
);
   bpc_pkg::evt_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
   assign full     = cnt_ff == 2'd2;
   assign nonempty = cnt_ff != 2'd0;
   assign pop_data = mem_ff[rp_ff];
endmodule

// File: src/bpc_back.sv
`timescale 1ns / 1ps
module bpc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             evt_valid,
   input  bpc_pkg::evt_type evt,
   output logic             evt_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpc_pkg::rsp_type rsp_data
);
   logic [15:0] word_ff, word_in;
   logic [31:0] grand_ff, grand_in;
   logic [16:0] wsum;
   logic [32:0] gsum;
   logic vld_ff, vld_in;
   bpc_pkg::rsp_type out_ff;

   // result slot frees when empty or being taken
   assign evt_pop = evt_valid && (!evt.close || !vld_ff || !rsp_stall);

   always_comb begin
      wsum = {1'b0, word_ff} + 17'(evt.retire) + 17'(evt.flush_cnt);
      word_in = wsum[16] ? bpc_pkg::WORD_MAX : wsum[15:0];
      gsum = {1'b0, grand_ff} + 33'(word_in);
      grand_in = gsum[32] ? bpc_pkg::GRAND_MAX : gsum[31:0];
   end

   always_comb begin
      if (evt_pop && evt.close) vld_in = 1'b1;
      else if (!rsp_stall) vld_in = 1'b0;
      else vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0; grand_ff <= '0; vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (evt_pop) begin
            if (evt.close) begin
               word_ff  <= '0;
               grand_ff <= evt.eot ? '0 : grand_in;
            end else begin
               word_ff <= word_in;
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (evt_pop && evt.close) out_ff <= '{word_in, grand_in, evt.eot};
   end
   assign rsp_valid = vld_ff;
   assign rsp_data  = out_ff;
endmodule

// File: src/bidirectional_pattern_coverage.sv
`timescale 1ns / 1ps
// A word end's result goes through the queue, then the registered result slot of the back.
// Throughput: one transaction per cycle while the queue is not full; the front window compare and the
// back tally are each combinational, and a two-entry queue parts them.
// Reset: synchronous, active high; clears patterns, window, tallies, queue.
module bidirectional_pattern_coverage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bpc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bpc_pkg::rsp_type               rsp_data
);
   bpc_pkg::evt_type evt, q_evt;
   logic full, nonempty, pop, take;

   // hold input while the queue is full
   assign req_stall = full;
   assign take      = req_valid && !full;

   bpc_front u_front (.clock, .reset, .csr_write, .csr_index, .csr_data,
                      .take, .req(req_data), .evt);
   bpc_queue u_queue (.clock, .reset, .push(take), .push_data(evt), .full,
                      .pop, .nonempty, .pop_data(q_evt));
   bpc_back u_back (.clock, .reset, .evt_valid(nonempty), .evt(q_evt),
                    .evt_pop(pop), .rsp_valid, .rsp_stall, .rsp_data);
endmodule

// File: src/bpc_checker.sv
`timescale 1ns / 1ps
module bpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bpc_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
   a_word_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.word_covered) <= rsp_data.total_covered)
      else $error("word exceeds total");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");
endmodule

bind bidirectional_pattern_coverage bpc_checker u_chk (.clock, .reset,
   .req_stall, .rsp_valid, .rsp_stall, .rsp_data);
